>>> sv/bflc_pkg.sv
// Shared types, constants and helpers for the bounded lookup cache.
package bflc_pkg;

	// Storage geometry
	localparam int DEPTH       = 16;
	localparam int KEY_BITS    = 32;
	localparam int HANDLE_BITS = 32;
	localparam int PTR_BITS    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS    = $clog2(DEPTH + 1);
	localparam int ENTRY_BITS  = KEY_BITS + HANDLE_BITS;

	// Fixed field widths of the ports
	localparam int OP_BITS      = 2;
	localparam int CFG_BITS     = 5;
	localparam int OUT_HDL_BITS = 32;
	localparam int OUT_CNT_BITS = 5;
	localparam int WIDE_BITS    = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;

	localparam logic [CFG_BITS-1:0] MAX_DEPTH_RST = CFG_BITS'(16);

	// Operation codes; the last one is unassigned and leaves the cache alone
	localparam logic [OP_BITS-1:0] OP_LOOKUP     = 2'd0;
	localparam logic [OP_BITS-1:0] OP_INSERT     = 2'd1;
	localparam logic [OP_BITS-1:0] OP_KEEP_FIRST = 2'd2;
	localparam logic [OP_BITS-1:0] OP_UNUSED     = 2'd3;

	typedef struct packed {
		logic [OP_BITS-1:0]     op;
		logic [KEY_BITS-1:0]    key;
		logic [HANDLE_BITS-1:0] handle;
	} req_t;

	typedef struct packed {
		logic                    found;
		logic [OUT_HDL_BITS-1:0] found_handle;
		logic [OUT_CNT_BITS-1:0] entry_count;
	} rsp_t;

	// Step a ring pointer toward older entries
	function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
		if (p == PTR_BITS'(DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_BITS'(1);
	endfunction

	// Step a ring pointer toward newer entries
	function automatic logic [PTR_BITS-1:0] ptr_dec(input logic [PTR_BITS-1:0] p);
		if (p == '0) begin
			return PTR_BITS'(DEPTH - 1);
		end
		return p - PTR_BITS'(1);
	endfunction

	// Fit a stored handle to the output field width
	function automatic logic [OUT_HDL_BITS-1:0] handle_out(input logic [HANDLE_BITS-1:0] h);
		logic [63:0] w;
		w = 64'(h);
		return w[OUT_HDL_BITS-1:0];
	endfunction

	// Fit the entry count to the output field width
	function automatic logic [OUT_CNT_BITS-1:0] count_out(input logic [CNT_BITS-1:0] c);
		logic [31:0] w;
		w = 32'(c);
		return w[OUT_CNT_BITS-1:0];
	endfunction

endpackage

>>> sv/bflc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bflc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic                                        rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port, data holds while idle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/bounded_fifo_lookup_cache.sv
// Top level of the bounded FIFO-replacement lookup cache.
// Entries live in a ring buffer RAM with the newest entry at the head pointer;
// an insert moves the head back one slot and writes there, so the oldest entry
// drops off the tail without any data movement. A lookup walks the ring from
// the newest entry through one RAM read and one key compare per cycle and stops
// at the first match. Insert, keep-first and unused ops skip the scan and pass
// from idle straight to the response state; a stalled result holds the
// sequencer there until the output register frees.
// The block takes one transaction at a time; the result sits in an output
// register, so the next request is accepted while a result still waits.
// max_depth writes are taken only while the sequencer is idle and clip the
// entry count at once.
module bounded_fifo_lookup_cache
	import bflc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  req_t                req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rsp_t                rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_BITS-1:0] cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_RESP = 2'd2;

	logic [1:0]             state_q;
	logic [CFG_BITS-1:0]    max_depth_q;
	logic [CNT_BITS-1:0]    count_q;
	logic [PTR_BITS-1:0]    head_q;
	logic [PTR_BITS-1:0]    rdptr_q;
	logic [CNT_BITS-1:0]    idx_q;
	logic                   cmp_valid_q;
	logic [KEY_BITS-1:0]    key_q;
	logic                   res_found_q;
	logic [HANDLE_BITS-1:0] res_handle_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic                   req_acc;
	logic                   cfg_acc;
	logic [WIDE_BITS-1:0]   lim_w;
	logic [CNT_BITS-1:0]    lim;
	logic [CNT_BITS-1:0]    ins_cnt;
	logic [CNT_BITS-1:0]    ins_clip;
	logic [PTR_BITS-1:0]    new_head;
	logic                   ram_wr;
	logic                   ram_rd;
	logic [ENTRY_BITS-1:0]  ram_rdata;
	logic [KEY_BITS-1:0]    rd_key;
	logic [HANDLE_BITS-1:0] rd_handle;
	logic                   hit;
	logic                   scan_done;
	logic                   rsp_push;

	// Handshakes
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign req_stall = (state_q != ST_IDLE) || cfg_valid;
	assign req_acc   = req_valid && !req_stall;

	// Depth limit in force: max_depth saturated at DEPTH
	always_comb begin
		if (WIDE_BITS'(cfg_acc ? cfg_data : max_depth_q) < WIDE_BITS'(DEPTH)) begin
			lim_w = WIDE_BITS'(cfg_acc ? cfg_data : max_depth_q);
		end else begin
			lim_w = WIDE_BITS'(DEPTH);
		end
		lim = lim_w[CNT_BITS-1:0];
	end

	// Count after an insert: drop the oldest when full, then add one
	always_comb begin
		if (count_q != '0 && count_q >= lim) begin
			ins_cnt = count_q - CNT_BITS'(1);
		end else begin
			ins_cnt = count_q;
		end
		if (ins_cnt > CNT_BITS'(DEPTH - 1)) begin
			ins_clip = CNT_BITS'(DEPTH - 1);
		end else begin
			ins_clip = ins_cnt;
		end
	end

	assign new_head = ptr_dec(head_q);
	assign ram_wr   = req_acc && (req.op == OP_INSERT);

	// Scan control: one read issued and one compare done per cycle
	assign rd_key    = ram_rdata[ENTRY_BITS-1:HANDLE_BITS];
	assign rd_handle = ram_rdata[HANDLE_BITS-1:0];
	assign hit       = cmp_valid_q && (rd_key == key_q);
	assign ram_rd    = (state_q == ST_SCAN) && (idx_q < count_q) && !hit;
	assign scan_done = hit || (!ram_rd && !cmp_valid_q);
	assign rsp_push  = (state_q == ST_RESP) && (!rsp_valid_q || !rsp_stall);

	bflc_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (DEPTH)
	) u_entries (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (new_head),
		.wr_data ({req.key, req.handle}),
		.rd_en   (ram_rd),
		.rd_addr (rdptr_q),
		.rd_data (ram_rdata)
	);

	// Sequencer, count, head pointer and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_depth_q <= MAX_DEPTH_RST;
			count_q     <= '0;
			head_q      <= '0;
			rdptr_q     <= '0;
			idx_q       <= '0;
			cmp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cmp_valid_q <= 1'b0;
					if (cfg_acc) begin
						max_depth_q <= cfg_data;
						if (count_q > lim) begin
							count_q <= lim;
						end
					end else if (req_acc) begin
						if (req.op == OP_LOOKUP) begin
							rdptr_q <= head_q;
							idx_q   <= '0;
							state_q <= ST_SCAN;
						end else begin
							if (req.op == OP_INSERT) begin
								head_q  <= new_head;
								count_q <= ins_clip + CNT_BITS'(1);
							end else if (req.op == OP_KEEP_FIRST) begin
								if (count_q > CNT_BITS'(1)) begin
									count_q <= CNT_BITS'(1);
								end
							end
							state_q <= ST_RESP;
						end
					end
				end
				ST_SCAN: begin
					cmp_valid_q <= ram_rd;
					if (ram_rd) begin
						rdptr_q <= ptr_inc(rdptr_q);
						idx_q   <= idx_q + CNT_BITS'(1);
					end
					if (scan_done) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					cmp_valid_q <= 1'b0;
					if (rsp_push) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					cmp_valid_q <= 1'b0;
				end
			endcase
		end
	end

	// Capture the lookup result or clear it for other ops
	always_ff @(posedge clk) begin
		if (req_acc) begin
			key_q        <= req.key;
			res_found_q  <= 1'b0;
			res_handle_q <= '0;
		end else if (state_q == ST_SCAN && hit) begin
			res_found_q  <= 1'b1;
			res_handle_q <= rd_handle;
		end
	end

	// Output register: load on push, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_push) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_push) begin
			rsp_q.found        <= res_found_q;
			rsp_q.found_handle <= handle_out(res_handle_q);
			rsp_q.entry_count  <= count_out(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Count never exceeds the storage depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(DEPTH))
		else $error("entry count above storage depth");

	// An accepted insert always leaves at least one entry
	a_insert_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.op == OP_INSERT) |=> (count_q != '0))
		else $error("insert left the cache empty");

	// A pending compare exists only while scanning
	a_cmp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_valid_q |-> (state_q == ST_SCAN))
		else $error("compare pending outside scan");

	// Scan never issues more reads than there are entries
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= count_q))
		else $error("scan ran past the entry count");

endmodule
